/* rtl/core/fisr_pkg.sv */
// ----------------------------------------------------------------------------
// fisr_pkg
// shared constants, types and helper functions for the inverse square root
// pipeline
// ----------------------------------------------------------------------------
package fisr_pkg;

    typedef logic [31:0] fbits_t;

    localparam int unsigned NEWTON_STEPS = 3;
    localparam int unsigned MUL_LAT      = 3;
    localparam int unsigned SUB_LAT      = 3;

    localparam fbits_t SEED_MAGIC = 32'h5f37_59df;
    localparam fbits_t ONE_HALF   = 32'h3f00_0000;
    localparam fbits_t THREE_HALF = 32'h3fc0_0000;
    localparam fbits_t DEFAULT_NAN = 32'hffc0_0000;
    localparam fbits_t QUIET_BIT  = 32'h0040_0000;

    // leading zero count of a 24-bit mantissa
    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] cnt;
        cnt = 5'd24;
        for (int i = 0; i < 24; i++)
        begin
            if (v[i])
            begin
                cnt = 5'(23 - i);
            end
        end
        return cnt;
    endfunction

    // leading zero count of a 27-bit extended mantissa
    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] cnt;
        cnt = 5'd27;
        for (int i = 0; i < 27; i++)
        begin
            if (v[i])
            begin
                cnt = 5'(26 - i);
            end
        end
        return cnt;
    endfunction

endpackage

/* rtl/core/fisr_delay.sv */
// ----------------------------------------------------------------------------
// fisr_delay
// enable-gated shift line that keeps side operands aligned with the units
// ----------------------------------------------------------------------------
module fisr_delay #(
    parameter int unsigned DEPTH = 3,
    parameter int unsigned WIDTH = 32
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

/* rtl/core/fisr_fmul.sv */
// ----------------------------------------------------------------------------
// fisr_fmul
// three-stage single-precision multiplier, round to nearest even,
// subnormals kept
// ----------------------------------------------------------------------------
module fisr_fmul (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  fisr_pkg::fbits_t a,
    input  fisr_pkg::fbits_t b,
    output logic            out_valid,
    output fisr_pkg::fbits_t result
);

    // stage 1: unpack, specials, operand normalize
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
    logic [23:0] ma, mb;
    logic [4:0]  lza, lzb;
    logic        spec;
    fisr_pkg::fbits_t spec_val;

    logic             v1_reg, v2_reg, v3_reg;
    logic             sp1_reg, sp2_reg;
    fisr_pkg::fbits_t spv1_reg, spv2_reg;
    logic             s1_reg, s2_reg;
    logic [23:0]      ma1_reg, mb1_reg;
    logic signed [10:0] ea1_reg, eb1_reg, es2_reg;
    logic [47:0]      p2_reg;
    fisr_pkg::fbits_t res_reg;

    always_comb
    begin
        a_nan  = (a[30:23] == 8'hff) && (a[22:0] != '0);
        b_nan  = (b[30:23] == 8'hff) && (b[22:0] != '0);
        a_inf  = (a[30:23] == 8'hff) && (a[22:0] == '0);
        b_inf  = (b[30:23] == 8'hff) && (b[22:0] == '0);
        a_zero = (a[30:0] == '0);
        b_zero = (b[30:0] == '0);
        sgn    = a[31] ^ b[31];
        ma     = {a[30:23] != 8'h00, a[22:0]};
        mb     = {b[30:23] != 8'h00, b[22:0]};
        lza    = fisr_pkg::lzc24(ma);
        lzb    = fisr_pkg::lzc24(mb);
        spec     = 1'b1;
        spec_val = '0;
        if (a_nan)
        begin
            spec_val = a | fisr_pkg::QUIET_BIT;
        end
        else if (b_nan)
        begin
            spec_val = b | fisr_pkg::QUIET_BIT;
        end
        else if ((a_inf && b_zero) || (a_zero && b_inf))
        begin
            spec_val = fisr_pkg::DEFAULT_NAN;
        end
        else if (a_inf || b_inf)
        begin
            spec_val = {sgn, 8'hff, 23'd0};
        end
        else if (a_zero || b_zero)
        begin
            spec_val = {sgn, 31'd0};
        end
        else
        begin
            spec = 1'b0;
        end
    end

    // stage 3: normalize, denormalize, round
    logic [47:0]        mn, ms, lost_mask;
    logic signed [10:0] be;
    logic [4:0]         sh;
    logic [7:0]         expf;
    logic [22:0]        frac;
    logic               g, st, rnd, ovf;

    always_comb
    begin
        mn   = p2_reg[47] ? p2_reg : {p2_reg[46:0], 1'b0};
        be   = es2_reg + 11'(p2_reg[47]) + 11'sd127;
        ovf  = be >= 11'sd255;
        sh   = '0;
        ms   = mn;
        lost_mask = '0;
        expf = be[7:0];
        if (be < 11'sd1)
        begin
            sh = (be < -11'sd24) ? 5'd25 : 5'(11'sd1 - be);
            ms = mn >> sh;
            lost_mask = (48'd1 << sh) - 48'd1;
            expf = '0;
        end
        frac = ms[46:24];
        g    = ms[23];
        st   = (|ms[22:0]) | (|(mn & lost_mask));
        rnd  = g & (st | frac[0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp1_reg  <= spec;
            spv1_reg <= spec_val;
            s1_reg   <= sgn;
            ma1_reg  <= ma << lza;
            mb1_reg  <= mb << lzb;
            ea1_reg  <= 11'(a[30:23] == 8'h00 ? 8'd1 : a[30:23]) - 11'(lza) - 11'sd127;
            eb1_reg  <= 11'(b[30:23] == 8'h00 ? 8'd1 : b[30:23]) - 11'(lzb) - 11'sd127;

            sp2_reg  <= sp1_reg;
            spv2_reg <= spv1_reg;
            s2_reg   <= s1_reg;
            p2_reg   <= ma1_reg * mb1_reg;
            es2_reg  <= ea1_reg + eb1_reg;

            if (sp2_reg)
            begin
                res_reg <= spv2_reg;
            end
            else if (ovf)
            begin
                res_reg <= {s2_reg, 8'hff, 23'd0};
            end
            else
            begin
                res_reg <= {s2_reg, {expf, frac} + 31'(rnd)};
            end
        end
    end

    assign out_valid = v3_reg;
    assign result    = res_reg;

endmodule

/* rtl/core/fisr_fsub.sv */
// ----------------------------------------------------------------------------
// fisr_fsub
// three-stage single-precision subtractor a - b, round to nearest even,
// subnormals kept
// ----------------------------------------------------------------------------
module fisr_fsub (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  fisr_pkg::fbits_t a,
    input  fisr_pkg::fbits_t b,
    output logic            out_valid,
    output fisr_pkg::fbits_t result
);

    fisr_pkg::fbits_t bn, lg, sm, spec_val;
    logic        a_nan, b_nan, a_inf, b_inf, spec;
    logic [7:0]  el, es, d;
    logic [26:0] ml, msm, mshift, lmask;
    logic [4:0]  dc;

    logic               v1_reg, v2_reg, v3_reg;
    logic               sp1_reg, sp2_reg;
    fisr_pkg::fbits_t   spv1_reg, spv2_reg;
    logic               s1_reg, s2_reg, sub1_reg;
    logic [7:0]         e1_reg, e2_reg;
    logic [26:0]        ml1_reg, ms1_reg;
    logic [27:0]        sum2_reg;
    logic [4:0]         lz2_reg;
    fisr_pkg::fbits_t   res_reg;

    always_comb
    begin
        bn    = {~b[31], b[30:0]};
        a_nan = (a[30:23] == 8'hff) && (a[22:0] != '0);
        b_nan = (b[30:23] == 8'hff) && (b[22:0] != '0);
        a_inf = (a[30:23] == 8'hff) && (a[22:0] == '0);
        b_inf = (b[30:23] == 8'hff) && (b[22:0] == '0);
        spec     = 1'b1;
        spec_val = '0;
        if (a_nan)
        begin
            spec_val = a | fisr_pkg::QUIET_BIT;
        end
        else if (b_nan)
        begin
            spec_val = b | fisr_pkg::QUIET_BIT;
        end
        else if (a_inf && b_inf && (a[31] != bn[31]))
        begin
            spec_val = fisr_pkg::DEFAULT_NAN;
        end
        else if (a_inf)
        begin
            spec_val = a;
        end
        else if (b_inf)
        begin
            spec_val = bn;
        end
        else if ((a[30:0] == '0) && (b[30:0] == '0))
        begin
            spec_val = {a[31] & bn[31], 31'd0};
        end
        else
        begin
            spec = 1'b0;
        end
        if (a[30:0] < bn[30:0])
        begin
            lg = bn;
            sm = a;
        end
        else
        begin
            lg = a;
            sm = bn;
        end
        el  = (lg[30:23] == 8'h00) ? 8'd1 : lg[30:23];
        es  = (sm[30:23] == 8'h00) ? 8'd1 : sm[30:23];
        ml  = {lg[30:23] != 8'h00, lg[22:0], 3'b000};
        msm = {sm[30:23] != 8'h00, sm[22:0], 3'b000};
        d   = el - es;
        dc  = (d > 8'd27) ? 5'd27 : d[4:0];
        lmask  = (27'd1 << dc) - 27'd1;
        mshift = msm >> dc;
        mshift[0] = mshift[0] | (|(msm & lmask));
    end

    // stage 2 add
    logic [27:0] sum;
    always_comb
    begin
        if (sub1_reg)
        begin
            sum = {1'b0, ml1_reg} - {1'b0, ms1_reg};
        end
        else
        begin
            sum = {1'b0, ml1_reg} + {1'b0, ms1_reg};
        end
    end

    // stage 3 normalize and round
    logic [26:0] n;
    logic [8:0]  e;
    logic [4:0]  lsh;
    logic [7:0]  expf;
    logic        rnd;
    always_comb
    begin
        lsh = '0;
        if (sum2_reg[27])
        begin
            n = {sum2_reg[27:2], sum2_reg[1] | sum2_reg[0]};
            e = {1'b0, e2_reg} + 9'd1;
        end
        else
        begin
            lsh = (9'(lz2_reg) > ({1'b0, e2_reg} - 9'd1)) ? 5'(e2_reg - 8'd1) : lz2_reg;
            n   = sum2_reg[26:0] << lsh;
            e   = {1'b0, e2_reg} - 9'(lsh);
        end
        expf = n[26] ? e[7:0] : 8'd0;
        rnd  = n[2] & (n[1] | n[0] | n[3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp1_reg  <= spec;
            spv1_reg <= spec_val;
            s1_reg   <= lg[31];
            sub1_reg <= lg[31] ^ sm[31];
            e1_reg   <= el;
            ml1_reg  <= ml;
            ms1_reg  <= mshift;

            sp2_reg  <= sp1_reg;
            spv2_reg <= spv1_reg;
            s2_reg   <= s1_reg;
            e2_reg   <= e1_reg;
            sum2_reg <= sum;
            lz2_reg  <= fisr_pkg::lzc27(sum[26:0]);

            if (sp2_reg)
            begin
                res_reg <= spv2_reg;
            end
            else if (sum2_reg == '0)
            begin
                res_reg <= '0;
            end
            else if (e >= 9'd255)
            begin
                res_reg <= {s2_reg, 8'hff, 23'd0};
            end
            else
            begin
                res_reg <= {s2_reg, {expf, n[25:3]} + 31'(rnd)};
            end
        end
    end

    assign out_valid = v3_reg;
    assign result    = res_reg;

endmodule

/* rtl/core/fisr_newton.sv */
// ----------------------------------------------------------------------------
// fisr_newton
// one newton step y * (1.5 - ((y * y) * half)) as a twelve-stage pipeline
// ----------------------------------------------------------------------------
module fisr_newton (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  fisr_pkg::fbits_t y_in,
    input  fisr_pkg::fbits_t half_in,
    output logic             out_valid,
    output fisr_pkg::fbits_t y_out,
    output fisr_pkg::fbits_t half_out
);

    localparam int unsigned YDLY = 2 * fisr_pkg::MUL_LAT + fisr_pkg::SUB_LAT;
    localparam int unsigned HDLY = fisr_pkg::MUL_LAT + fisr_pkg::SUB_LAT;

    logic             v_sq, v_p, v_d;
    fisr_pkg::fbits_t sq, prod, diff, y_d, half_d, half_d2;

    fisr_fmul u_mul_sq (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
        .a(y_in), .b(y_in), .out_valid(v_sq), .result(sq)
    );

    fisr_delay #(.DEPTH(fisr_pkg::MUL_LAT), .WIDTH(32)) u_dly_half (
        .clk(clk), .en(en), .din(half_in), .dout(half_d)
    );

    fisr_fmul u_mul_prod (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_sq),
        .a(sq), .b(half_d), .out_valid(v_p), .result(prod)
    );

    fisr_fsub u_sub (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_p),
        .a(fisr_pkg::THREE_HALF), .b(prod), .out_valid(v_d), .result(diff)
    );

    fisr_delay #(.DEPTH(YDLY), .WIDTH(32)) u_dly_y (
        .clk(clk), .en(en), .din(y_in), .dout(y_d)
    );

    fisr_delay #(.DEPTH(HDLY + fisr_pkg::MUL_LAT), .WIDTH(32)) u_dly_half2 (
        .clk(clk), .en(en), .din(half_d), .dout(half_d2)
    );

    fisr_fmul u_mul_res (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_d),
        .a(y_d), .b(diff), .out_valid(out_valid), .result(y_out)
    );

    assign half_out = half_d2;

endmodule

/* rtl/core/fast_inverse_square_root_unit.sv */
// ----------------------------------------------------------------------------
// fast_inverse_square_root_unit
// float32 inverse square root: magic-constant seed and newton refinement
// ----------------------------------------------------------------------------
//  channel  dir  signals                         content
//  s_axis   in   tvalid tready tdata[31:0]       operand_bits
//  m_axis   out  tvalid tready tdata[31:0]       result_bits
//
//  one operand per clock while the output is not held; the path runs through
//  a three-stage half multiply, twelve stages per newton step and an output register
//  every float unit is a three-stage pipeline sharing one advance enable
//  reset clears only the valid bits; the pipeline is empty after reset
//  a held output freezes the whole pipeline; nothing is lost or repeated
// ----------------------------------------------------------------------------
module fast_inverse_square_root_unit #(
    parameter int unsigned NEWTON_STEPS = fisr_pkg::NEWTON_STEPS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] operand_bits
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] result_bits
);

    logic             en;
    logic             v_chain [NEWTON_STEPS+1];
    fisr_pkg::fbits_t y_chain [NEWTON_STEPS+1];
    fisr_pkg::fbits_t h_chain [NEWTON_STEPS+1];
    fisr_pkg::fbits_t seed;
    logic             out_valid_reg, out_valid_next;
    fisr_pkg::fbits_t out_data_reg, out_data_next;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign seed = fisr_pkg::SEED_MAGIC - {s_axis_tdata[31], s_axis_tdata[31:1]};

    fisr_fmul u_mul_half (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_axis_tvalid),
        .a(fisr_pkg::ONE_HALF), .b(s_axis_tdata),
        .out_valid(v_chain[0]), .result(h_chain[0])
    );

    fisr_delay #(.DEPTH(fisr_pkg::MUL_LAT), .WIDTH(32)) u_dly_seed (
        .clk(clk), .en(en), .din(seed), .dout(y_chain[0])
    );

    for (genvar i = 0; i < NEWTON_STEPS; i++)
    begin : g_step
        fisr_newton u_step (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(v_chain[i]), .y_in(y_chain[i]), .half_in(h_chain[i]),
            .out_valid(v_chain[i+1]), .y_out(y_chain[i+1]), .half_out(h_chain[i+1])
        );
    end

    assign out_valid_next = v_chain[NEWTON_STEPS];
    assign out_data_next  = y_chain[NEWTON_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid
    ) else $error("input stalled with empty output register");

    a_ready_when_drained: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready |-> s_axis_tready
    ) else $error("input stalled while output drains");

    a_hold_on_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s_axis_tready |=> $stable(y_chain[NEWTON_STEPS])
    ) else $error("pipeline moved during stall");

endmodule
